// ===== rtl/division_magic_number_generator_defines.svh =====
// Assertion macros for the division magic number generator
`ifndef DIVISION_MAGIC_NUMBER_GENERATOR_DEFINES_SVH
`define DIVISION_MAGIC_NUMBER_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DMNG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("dmng check failed");
`define DMNG_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("dmng check failed");
`else
`define DMNG_ASSERT(name, clk, rst, prop)
`define DMNG_ASSERT_NR(name, clk, prop)
`endif
`endif

// ===== rtl/dmng_pkg.sv =====
// Shared types and constants for the division magic number generator
`timescale 1ns / 1ps
`default_nettype none
package dmng_pkg;
  localparam int unsigned DW = 64;

  localparam logic [1:0] ST_MAGIC   = 2'd0;
  localparam logic [1:0] ST_POW2    = 2'd1;
  localparam logic [1:0] ST_TRIVIAL = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_TZ,
    S_DIV_A,
    S_DIV_B,
    S_DIV_C,
    S_LOOP,
    S_CHECK,
    S_DONE
  } dmng_state_t;
endpackage
`default_nettype wire

// ===== rtl/dmng_div.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module dmng_div #(
  parameter int unsigned WIDTH = dmng_pkg::DW
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] num,
  input  wire logic [WIDTH-1:0] den,
  output logic                  done,
  output logic [WIDTH-1:0]      quot,
  output logic [WIDTH-1:0]      rem
);
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] den_r;
  logic [WIDTH:0]   acc;
  logic [CW-1:0]    cnt;
  logic [WIDTH:0]   acc_sh;
  logic             fits;

  assign acc_sh = {acc[WIDTH-1:0], quot[WIDTH-1]};
  assign fits   = acc_sh >= {1'b0, den_r};
  assign rem    = acc[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(WIDTH);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_r <= den;
      acc   <= '0;
    end else if (cnt != '0) begin
      quot <= {quot[WIDTH-2:0], fits};
      acc  <= fits ? (acc_sh - {1'b0, den_r}) : acc_sh;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/division_magic_number_generator.sv =====
// Division magic number generator: top level with sequencer and search step
//
// Takes a divisor, a signed/unsigned kind and a 32/64-bit width, and returns the
// multiply-shift constants for division by that divisor. One item at a time:
// in_stall stays high from the accepting transfer until the result transfer.
// A search runs three divisions on the shared restoring divider, then the
// quotient-doubling loop, an S_LOOP then an S_CHECK state per step. The step
// count is the found shift plus one, at most 33 or 65 steps. An even unsigned
// divisor that needs add-back runs the whole search twice, with a trailing-zero
// count of one bit per cycle in between. Zero and trivial divisors skip the
// search; powers of two run only the trailing-zero count.
`timescale 1ns / 1ps
`default_nettype none
`include "division_magic_number_generator_defines.svh"
module division_magic_number_generator (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    kind,
  input  wire logic                    wide,
  input  wire logic [dmng_pkg::DW-1:0] divisor,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   status,
  output logic [dmng_pkg::DW-1:0]      multiplier,
  output logic                         fixup,
  output logic [5:0]                   pre_shift,
  output logic [6:0]                   post_shift
);
  localparam int unsigned WIDTH = dmng_pkg::DW;
  localparam int unsigned HW = WIDTH / 2;

  dmng_pkg::dmng_state_t state, state_next;

  logic             kind_r, wide_r, neg, pass2, launched, add;
  logic [WIDTH-1:0] d, nc, q1, r1, q2, r2, tzv;
  logic [5:0]       lz, tzc;
  logic [7:0]       p;

  logic [WIDTH-1:0] m, top, all, in_m, in_ad;
  logic [7:0]       w8;
  logic             in_neg;

  logic             div_start, div_done;
  logic [WIDTH-1:0] div_num, div_den, div_q, div_r;

  logic [WIDTH-1:0] q1n, r1n, q2n, r2n, delta, magf, magu;
  logic             addn, cont, in_fire, out_fire;

  assign m   = wide_r ? '1 : {{HW{1'b0}}, {HW{1'b1}}};
  assign top = wide_r ? {1'b1, {(WIDTH-1){1'b0}}} : {{HW{1'b0}}, 1'b1, {(HW-1){1'b0}}};
  assign all = m >> lz;
  assign w8  = wide_r ? 8'd64 : 8'd32;

  assign in_m   = wide ? divisor : {{HW{1'b0}}, divisor[HW-1:0]};
  assign in_neg = kind && (wide ? divisor[WIDTH-1] : divisor[HW-1]);
  assign in_ad  = in_neg ? ((~in_m + WIDTH'(1)) & (wide ? '1 : {{HW{1'b0}}, {HW{1'b1}}}))
                         : in_m;

  assign in_stall = (state != dmng_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  dmng_div #(.WIDTH(WIDTH)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q),
    .rem  (div_r)
  );

  // divider operands per phase
  always_comb begin
    div_num = top;
    div_den = d;
    case (state)
      dmng_pkg::S_DIV_A: div_num = kind_r ? (top + WIDTH'(neg))
                                          : ((all + WIDTH'(1) - d) & m);
      dmng_pkg::S_DIV_B: div_den = nc;
      dmng_pkg::S_DIV_C: div_num = kind_r ? top : (top - WIDTH'(1));
      default: div_num = top;
    endcase
  end

  // one quotient-doubling step
  always_comb begin
    addn = add;
    if (kind_r) begin
      q1n = {q1[WIDTH-2:0], 1'b0} & m;
      r1n = {r1[WIDTH-2:0], 1'b0} & m;
      if (r1n >= nc) begin
        q1n = (q1n + WIDTH'(1)) & m;
        r1n = (r1n - nc) & m;
      end
      q2n = {q2[WIDTH-2:0], 1'b0} & m;
      r2n = {r2[WIDTH-2:0], 1'b0} & m;
      if (r2n >= d) begin
        q2n = (q2n + WIDTH'(1)) & m;
        r2n = (r2n - d) & m;
      end
    end else begin
      if (r1 >= ((nc - r1) & m)) begin
        q1n = {q1[WIDTH-2:0], 1'b1} & m;
        r1n = ({r1[WIDTH-2:0], 1'b0} - nc) & m;
      end else begin
        q1n = {q1[WIDTH-2:0], 1'b0} & m;
        r1n = {r1[WIDTH-2:0], 1'b0} & m;
      end
      if (((r2 + WIDTH'(1)) & m) >= ((d - r2) & m)) begin
        if (q2 >= (top - WIDTH'(1))) addn = 1'b1;
        q2n = {q2[WIDTH-2:0], 1'b1} & m;
        r2n = ({r2[WIDTH-2:0], 1'b1} - d) & m;
      end else begin
        if (q2 >= top) addn = 1'b1;
        q2n = {q2[WIDTH-2:0], 1'b0} & m;
        r2n = {r2[WIDTH-2:0], 1'b1} & m;
      end
    end
  end

  assign delta = kind_r ? ((d - r2) & m) : ((d - WIDTH'(1) - r2) & m);
  assign cont  = (p < {w8[6:0], 1'b0}) && ((q1 < delta) || ((q1 == delta) && (r1 == '0)));
  assign magu  = (q2 + WIDTH'(1)) & m;
  assign magf  = neg ? ((~magu + WIDTH'(1)) & m) : magu;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmng_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      dmng_pkg::S_IDLE: begin
        if (in_fire) state_next = dmng_pkg::S_CLASSIFY;
      end
      dmng_pkg::S_CLASSIFY: begin
        if (d == '0 || d == WIDTH'(1)) begin
          state_next = dmng_pkg::S_DONE;
        end else if ((d & (d - WIDTH'(1))) == '0) begin
          state_next = dmng_pkg::S_TZ;
        end else begin
          state_next = dmng_pkg::S_DIV_A;
        end
      end
      dmng_pkg::S_TZ: begin
        if (tzv[0]) state_next = pass2 ? dmng_pkg::S_DIV_A : dmng_pkg::S_DONE;
      end
      dmng_pkg::S_DIV_A, dmng_pkg::S_DIV_B, dmng_pkg::S_DIV_C: begin
        div_start = !launched;
        if (div_done) begin
          unique case (state)
            dmng_pkg::S_DIV_A: state_next = dmng_pkg::S_DIV_B;
            dmng_pkg::S_DIV_B: state_next = dmng_pkg::S_DIV_C;
            default:           state_next = dmng_pkg::S_LOOP;
          endcase
        end
      end
      dmng_pkg::S_LOOP: state_next = dmng_pkg::S_CHECK;
      dmng_pkg::S_CHECK: begin
        if (cont) begin
          state_next = dmng_pkg::S_LOOP;
        end else if (!kind_r && !pass2 && add && !d[0]) begin
          state_next = dmng_pkg::S_TZ;
        end else begin
          state_next = dmng_pkg::S_DONE;
        end
      end
      dmng_pkg::S_DONE: begin
        if (out_fire) state_next = dmng_pkg::S_IDLE;
      end
      default: state_next = dmng_pkg::S_IDLE;
    endcase
  end

  assign out_valid = (state == dmng_pkg::S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (div_done) begin
      launched <= 1'b0;
    end else if (div_start) begin
      launched <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dmng_pkg::S_IDLE: begin
        if (in_fire) begin
          kind_r     <= kind;
          wide_r     <= wide;
          neg        <= in_neg;
          d          <= in_ad;
          lz         <= '0;
          pass2      <= 1'b0;
          status     <= dmng_pkg::ST_MAGIC;
          multiplier <= '0;
          fixup      <= 1'b0;
          pre_shift  <= '0;
          post_shift <= '0;
        end
      end
      dmng_pkg::S_CLASSIFY: begin
        tzv <= d;
        tzc <= '0;
        if (d == '0) begin
          status <= dmng_pkg::ST_ZERO;
        end else if (d == WIDTH'(1)) begin
          status <= dmng_pkg::ST_TRIVIAL;
        end
      end
      dmng_pkg::S_TZ: begin
        if (tzv[0]) begin
          if (pass2) begin
            // redo on the odd part, dividend pre-shifted
            d         <= tzv;
            lz        <= tzc;
            pre_shift <= tzc;
          end else begin
            status     <= dmng_pkg::ST_POW2;
            post_shift <= {1'b0, tzc};
          end
        end else begin
          tzv <= tzv >> 1;
          tzc <= tzc + 6'd1;
        end
      end
      dmng_pkg::S_DIV_A: begin
        add <= 1'b0;
        p   <= w8 - 8'd1;
        if (div_done) begin
          nc <= kind_r ? ((top + WIDTH'(neg) - WIDTH'(1) - div_r) & m) : ((all - div_r) & m);
        end
      end
      dmng_pkg::S_DIV_B: begin
        if (div_done) begin
          q1 <= div_q;
          r1 <= div_r;
        end
      end
      dmng_pkg::S_DIV_C: begin
        if (div_done) begin
          q2 <= div_q;
          r2 <= div_r;
        end
      end
      dmng_pkg::S_LOOP: begin
        q1  <= q1n;
        r1  <= r1n;
        q2  <= q2n;
        r2  <= r2n;
        add <= addn;
        p   <= p + 8'd1;
      end
      dmng_pkg::S_CHECK: begin
        if (!cont) begin
          if (!kind_r && !pass2 && add && !d[0]) begin
            pass2 <= 1'b1;
            tzv   <= d;
            tzc   <= '0;
          end else begin
            multiplier <= magf;
            if (!kind_r && !pass2 && add) begin
              fixup      <= 1'b1;
              post_shift <= 7'(p - w8 - 8'd1);
            end else begin
              fixup      <= add;
              post_shift <= 7'(p - w8);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  `DMNG_ASSERT(a_accept_busy, clk, rst, in_fire |=> !out_valid && in_stall)
  `DMNG_ASSERT(a_special_no_magic, clk, rst, out_valid && (status != dmng_pkg::ST_MAGIC) |-> (multiplier == '0) && !fixup && (pre_shift == '0))
  `DMNG_ASSERT(a_loop_bound, clk, rst, (state == dmng_pkg::S_CHECK) |-> (p <= {w8[6:0], 1'b0}))
  `DMNG_ASSERT_NR(a_reset_idle, clk, rst |=> !out_valid && !in_stall)
endmodule
`default_nettype wire
